/* rtl/core/serial_audio_frame_receiver_core_macros.svh */
// Assertion macros for the serial audio frame receiver core.
// Used by the checker; no other dependencies.
`ifndef SERIAL_AUDIO_FRAME_RECEIVER_CORE_MACROS_SVH
`define SERIAL_AUDIO_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SAFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SAFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/safr_pkg.sv */
// Types and constants for the serial audio frame receiver.
// No dependencies.
`timescale 1ns / 1ps
package safr_pkg;

  localparam int unsigned POS_W       = 4;
  localparam int unsigned FULL_LEN    = 10;
  localparam int unsigned SHORT_LEN   = 8;
  localparam int unsigned STORE_BASE  = 3;
  localparam int unsigned STORE_DEPTH = 6;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);

  localparam logic [POS_W-1:0] POS_START   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_VERSION = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SHORT   = POS_W'(SHORT_LEN - 1);
  localparam logic [POS_W-1:0] POS_END     = POS_W'(FULL_LEN - 1);

  typedef enum logic [1:0] {
    REG_START   = 2'd0,
    REG_VERSION = 2'd1,
    REG_LENGTH  = 2'd2,
    REG_END     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] version_byte;
    logic [7:0] length_byte;
    logic [7:0] end_byte;
  } safr_cfg_t;

  typedef struct packed {
    logic        frame_done;
    logic        frame_valid;
    logic        has_checksum;
    logic [7:0]  msg_id;
    logic [7:0]  feedback_flag;
    logic [15:0] payload_word;
  } safr_result_t;

endpackage

/* rtl/core/safr_ifs.sv */
// Handshake channel interfaces: received bytes, results, configuration writes.
// Depends on safr_pkg.
`timescale 1ns / 1ps
interface safr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface safr_res_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic        frame_valid;
  logic        has_checksum;
  logic [7:0]  msg_id;
  logic [7:0]  feedback_flag;
  logic [15:0] payload_word;
  modport source (output valid, output frame_done, output frame_valid,
                  output has_checksum, output msg_id, output feedback_flag,
                  output payload_word, input ready);
  modport sink (input valid, input frame_done, input frame_valid,
                input has_checksum, input msg_id, input feedback_flag,
                input payload_word, output ready);
endinterface

interface safr_cfg_if
  import safr_pkg::*;
;
  logic       valid;
  logic       ready;
  cfg_reg_e   reg_index;
  logic [7:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* rtl/core/safr_cfg_regs.sv */
// Template byte registers written over the configuration channel.
// Depends on safr_pkg.
`timescale 1ns / 1ps
module safr_cfg_regs
  import safr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  cfg_reg_e   wr_index_i,
  input  logic [7:0] wr_data_i,
  output safr_cfg_t  cfg_o
);

  safr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_START:   cfg_d.start_byte   = wr_data_i;
        REG_VERSION: cfg_d.version_byte = wr_data_i;
        REG_LENGTH:  cfg_d.length_byte  = wr_data_i;
        REG_END:     cfg_d.end_byte     = wr_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= 8'd126;
      cfg_q.version_byte <= 8'd255;
      cfg_q.length_byte  <= 8'd6;
      cfg_q.end_byte     <= 8'd239;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/safr_framer.sv */
// Frame position tracking, body byte store and checksum check.
// Depends on safr_pkg; result is combinational from the current byte.
`timescale 1ns / 1ps
module safr_framer
  import safr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   rx_byte_i,
  input  safr_cfg_t    cfg_i,
  output safr_result_t result_o
);

  logic [POS_W-1:0]       pos_q, pos_d;
  logic [POS_W-1:0]       pos_eff;
  logic [7:0]             store_q [STORE_DEPTH];
  logic                   store_we;
  logic [STORE_IDX_W-1:0] store_idx;
  logic [7:0]             expect_byte;
  logic [15:0]            sum;
  logic                   emit_full;
  logic                   emit_short;

  assign pos_eff   = (pos_q >= POS_W'(FULL_LEN)) ? POS_START : pos_q;
  assign store_idx = STORE_IDX_W'(pos_eff - POS_W'(STORE_BASE));

  assign sum = 16'(cfg_i.version_byte) + 16'(cfg_i.length_byte)
             + 16'(store_q[0]) + 16'(store_q[1]) + 16'(store_q[2]) + 16'(store_q[3])
             + {store_q[4], store_q[5]};

  always_comb begin
    expect_byte = cfg_i.end_byte;
    case (pos_eff)
      POS_START:   expect_byte = cfg_i.start_byte;
      POS_VERSION: expect_byte = cfg_i.version_byte;
      POS_LENGTH:  expect_byte = cfg_i.length_byte;
      default:     expect_byte = cfg_i.end_byte;
    endcase
  end

  always_comb begin
    pos_d      = pos_eff;
    store_we   = 1'b0;
    emit_full  = 1'b0;
    emit_short = 1'b0;
    case (pos_eff)
      POS_START, POS_VERSION, POS_LENGTH, POS_END: begin
        if (rx_byte_i == expect_byte) begin
          if (pos_eff == POS_END) begin
            emit_full = 1'b1;
            pos_d     = POS_START;
          end else begin
            pos_d = pos_eff + POS_W'(1);
          end
        end else begin
          pos_d = (rx_byte_i == cfg_i.start_byte) ? POS_VERSION : POS_START;
        end
      end
      default: begin
        if (pos_eff == POS_SHORT && rx_byte_i == cfg_i.end_byte) begin
          emit_short = 1'b1;
          pos_d      = POS_START;
        end else begin
          store_we = 1'b1;
          pos_d    = pos_eff + POS_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    result_o = '0;
    if (emit_full || emit_short) begin
      result_o.frame_done    = 1'b1;
      result_o.frame_valid   = emit_short || (sum == 16'd0);
      result_o.has_checksum  = emit_full;
      result_o.msg_id        = store_q[0];
      result_o.feedback_flag = store_q[1];
      result_o.payload_word  = {store_q[2], store_q[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_START;
    end else if (accept_i) begin
      pos_q <= pos_d;
    end
  end

  // body bytes: no reset, each entry written only within its frame
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (accept_i && store_we && store_idx == STORE_IDX_W'(i)) begin
        store_q[i] <= rx_byte_i;
      end
    end
  end

endmodule

/* rtl/core/safr_out_stage.sv */
// Result register with valid/ready; takes a new result while the old one drains.
// Depends on safr_pkg.
`timescale 1ns / 1ps
module safr_out_stage
  import safr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  safr_result_t result_i,
  output logic         free_o,
  output logic         valid_o,
  input  logic         ready_i,
  output safr_result_t result_o
);

  logic         valid_q, valid_d;
  safr_result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* rtl/core/serial_audio_frame_receiver_core.sv */
// Channel     | dir | payload                                    | transfer when
// rx_i        | in  | rx_byte                                    | valid & ready
// res_o       | out | frame_done, frame_valid, has_checksum,     | valid & ready
//             |     | msg_id, feedback_flag, payload_word        |
// cfg_i       | in  | reg_index, wr_data                         | valid & ready
//
// One byte per cycle while rx_i.ready is high; each byte gives one result, valid in the cycle after its transfer.
// The result is held in the single result register after the framing logic.
// rx_i.ready drops only while a result is held and res_o.ready is low.
// Reset clears the frame position and loads the default template bytes.
// cfg_i is always ready. Depends on safr_pkg and the channel interfaces.
`timescale 1ns / 1ps
module serial_audio_frame_receiver_core
  import safr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  safr_rx_if.sink      rx_i,
  safr_res_if.source   res_o,
  safr_cfg_if.sink     cfg_i
);

  safr_cfg_t    cfg;
  safr_result_t res_next;
  safr_result_t res_held;
  logic         out_free;
  logic         rx_xfer;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = out_free;
  assign rx_xfer     = rx_i.valid && out_free;

  safr_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wr_data),
    .cfg_o      (cfg)
  );

  safr_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_xfer),
    .rx_byte_i (rx_i.rx_byte),
    .cfg_i     (cfg),
    .result_o  (res_next)
  );

  safr_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (rx_xfer),
    .result_i (res_next),
    .free_o   (out_free),
    .valid_o  (res_o.valid),
    .ready_i  (res_o.ready),
    .result_o (res_held)
  );

  assign res_o.frame_done    = res_held.frame_done;
  assign res_o.frame_valid   = res_held.frame_valid;
  assign res_o.has_checksum  = res_held.has_checksum;
  assign res_o.msg_id        = res_held.msg_id;
  assign res_o.feedback_flag = res_held.feedback_flag;
  assign res_o.payload_word  = res_held.payload_word;

endmodule

/* rtl/core/safr_checker.sv */
// Port-level checks for serial_audio_frame_receiver_core, attached by bind.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "serial_audio_frame_receiver_core_macros.svh"
module safr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        frame_done_i,
  input logic        frame_valid_i,
  input logic        has_checksum_i,
  input logic [7:0]  msg_id_i,
  input logic [7:0]  feedback_flag_i,
  input logic [15:0] payload_word_i
);

  // every byte transfer yields a result in the next cycle
  `SAFR_ASSERT_NXT(a_byte_gives_result, clk_i, rst_ni, rx_valid_i && rx_ready_i, res_valid_i)
  // a drained output never blocks the byte side
  `SAFR_ASSERT_IMP(a_ready_follows, clk_i, rst_ni, !res_valid_i || res_ready_i, rx_ready_i)
  // no completed frame: all fields zero
  `SAFR_ASSERT_IMP(a_idle_zero, clk_i, rst_ni, res_valid_i && !frame_done_i, !frame_valid_i && !has_checksum_i && msg_id_i == 8'd0 && feedback_flag_i == 8'd0 && payload_word_i == 16'd0)
  // short frames are always valid
  `SAFR_ASSERT_IMP(a_short_valid, clk_i, rst_ni, res_valid_i && frame_done_i && !has_checksum_i, frame_valid_i)
  // a stalled result holds
  `SAFR_ASSERT_NXT(a_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(frame_done_i) && $stable(payload_word_i))

endmodule

bind serial_audio_frame_receiver_core safr_checker u_safr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rx_valid_i      (rx_i.valid),
  .rx_ready_i      (rx_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .frame_done_i    (res_o.frame_done),
  .frame_valid_i   (res_o.frame_valid),
  .has_checksum_i  (res_o.has_checksum),
  .msg_id_i        (res_o.msg_id),
  .feedback_flag_i (res_o.feedback_flag),
  .payload_word_i  (res_o.payload_word)
);

/* tb/testbench.sv */
// Self-checking testbench for serial_audio_frame_receiver_core: drives received bytes,
// template writes and random back-pressure, predicts each per-byte result and compares.
// Depends on safr_pkg, the channel interfaces in safr_ifs.sv and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import safr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef logic [7:0] frame_t [FULL_LEN];

  logic clk;
  logic rst_n;

  safr_rx_if  rx_ch ();
  safr_res_if res_ch ();
  safr_cfg_if cfg_ch ();

  serial_audio_frame_receiver_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // parser shadow state
  safr_cfg_t    tmpl;
  logic [3:0]   frame_pos;
  logic [7:0]   body_bytes [STORE_DEPTH];
  safr_result_t byte_reports [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned stall_left;
  int unsigned cycle_count;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic safr_result_t frame_byte(logic [7:0] b);
    safr_result_t r;
    logic [3:0]   p;
    logic [7:0]   want;
    logic [15:0]  sum;
    r = '0;
    p = (frame_pos >= FULL_LEN) ? POS_START : frame_pos;
    if (p == POS_START || p == POS_VERSION || p == POS_LENGTH || p == POS_END) begin
      case (p)
        POS_START:   want = tmpl.start_byte;
        POS_VERSION: want = tmpl.version_byte;
        POS_LENGTH:  want = tmpl.length_byte;
        default:     want = tmpl.end_byte;
      endcase
      if (b != want) begin
        frame_pos = (b == tmpl.start_byte) ? POS_VERSION : POS_START;
      end else if (p != POS_END) begin
        frame_pos = p + 4'd1;
      end else begin
        // checksum uses the live version/length registers
        sum = 16'(tmpl.version_byte) + 16'(tmpl.length_byte) + 16'(body_bytes[0])
            + 16'(body_bytes[1]) + 16'(body_bytes[2]) + 16'(body_bytes[3])
            + {body_bytes[4], body_bytes[5]};
        r.frame_done   = 1'b1;
        r.frame_valid  = (sum == 16'd0);
        r.has_checksum = 1'b1;
        frame_pos      = POS_START;
      end
    end else if (p == POS_SHORT && b == tmpl.end_byte) begin
      r.frame_done   = 1'b1;
      r.frame_valid  = 1'b1;
      r.has_checksum = 1'b0;
      frame_pos      = POS_START;
    end else begin
      body_bytes[p - STORE_BASE] = b;
      frame_pos = p + 4'd1;
    end
    if (r.frame_done) begin
      r.msg_id        = body_bytes[0];
      r.feedback_flag = body_bytes[1];
      r.payload_word  = {body_bytes[2], body_bytes[3]};
    end
    return r;
  endfunction

  function automatic frame_t full_frame(logic [7:0] id, logic [7:0] fb, logic [15:0] word);
    frame_t      f;
    logic [15:0] s;
    s = 16'(tmpl.version_byte) + 16'(tmpl.length_byte) + 16'(id) + 16'(fb)
      + 16'(word[15:8]) + 16'(word[7:0]);
    s = 16'd0 - s;
    f = '{tmpl.start_byte, tmpl.version_byte, tmpl.length_byte, id, fb,
          word[15:8], word[7:0], s[15:8], s[7:0], tmpl.end_byte};
    return f;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch on result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    safr_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (byte_reports.size() == 0) begin
        report_mismatch("result with no byte pending");
      end else begin
        want = byte_reports.pop_front();
        check_field("frame_done", 16'(res_ch.frame_done), 16'(want.frame_done));
        check_field("frame_valid", 16'(res_ch.frame_valid), 16'(want.frame_valid));
        check_field("has_checksum", 16'(res_ch.has_checksum), 16'(want.has_checksum));
        check_field("msg_id", 16'(res_ch.msg_id), 16'(want.msg_id));
        check_field("feedback_flag", 16'(res_ch.feedback_flag), 16'(want.feedback_flag));
        check_field("payload_word", res_ch.payload_word, want.payload_word);
      end
      results_seen++;
      stall_left = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // entered and left at a falling edge; valid stays high for a following byte
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    byte_reports.push_back(frame_byte(b));
    @(negedge clk);
  endtask

  task automatic send_bytes(frame_t f, int first, int last);
    for (int i = first; i <= last; i++) send_byte(f[i]);
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (byte_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_template(safr_cfg_t t, logic [3:0] mask);
    logic [7:0] val;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        // register i sits in byte 3-i of the packed template
        val = t[8*(3-i) +: 8];
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= cfg_reg_e'(i);
        cfg_ch.wr_data   <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        tmpl[8*(3-i) +: 8] = val;
        @(negedge clk);
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_traffic(int budget);
    frame_t f;
    int     sent;
    int     n;
    int     pick;
    sent = 0;
    while (sent < budget) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      f = full_frame(rand_byte(), rand_byte(), {rand_byte(), rand_byte()});
      n = FULL_LEN;
      if (pick < 45) begin
        n = FULL_LEN;
      end else if (pick < 55) begin
        f[8] = f[8] ^ 8'($urandom_range(1, 255));
      end else if (pick < 70) begin
        f[POS_SHORT] = tmpl.end_byte;
        n = SHORT_LEN;
      end else if (pick < 80) begin
        n = $urandom_range(1, FULL_LEN - 1);
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: f[POS_START]   = 8'($urandom_range(0, 255));
          1: f[POS_VERSION] = 8'($urandom_range(0, 255));
          2: f[POS_LENGTH]  = 8'($urandom_range(0, 255));
          default: f[POS_END] = 8'($urandom_range(0, 255));
        endcase
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          f[i] = ($urandom_range(0, 3) == 0) ? tmpl.start_byte : 8'($urandom_range(0, 255));
      end
      send_bytes(f, 0, n - 1);
      sent += n;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_default_frames();
    frame_t f;
    f = full_frame(8'h00, 8'hFF, 16'hFFFF);
    send_bytes(f, 0, FULL_LEN - 1);
    f = full_frame(8'hFF, 8'h00, 16'h0000);
    f[POS_SHORT] = tmpl.end_byte;
    send_bytes(f, 0, SHORT_LEN - 1);
    // repeated start byte resyncs to the version slot, junk drops back to idle
    send_byte(8'h00);
    send_byte(tmpl.start_byte);
    send_byte(tmpl.start_byte);
    send_byte(8'h00);
    settle();
  endtask

  task automatic test_reconfig_mid_frame();
    frame_t    f;
    safr_cfg_t t;
    f = full_frame(8'h3F, 8'h01, 16'h0102);
    send_bytes(f, 0, 3);
    settle();
    t = tmpl;
    t.version_byte = tmpl.version_byte ^ 8'($urandom_range(1, 255));
    program_template(t, 4'b0010);
    f = full_frame(8'h3F, 8'h01, 16'h0102);
    send_bytes(f, 4, FULL_LEN - 1);
    settle();
  endtask

  task automatic test_template_extremes();
    program_template('0, 4'hF);
    run_traffic(120);
    settle();
    program_template('1, 4'hF);
    run_traffic(120);
    settle();
  endtask

  task automatic test_random_templates();
    safr_cfg_t t;
    repeat (3) begin
      t = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
      program_template(t, 4'hF);
      run_traffic(130);
      settle();
    end
  endtask

  task automatic test_default_traffic();
    program_template({8'd126, 8'd255, 8'd6, 8'd239}, 4'hF);
    run_traffic(200);
    settle();
  endtask

  initial begin
    rst_n            = 1'b0;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = 8'h00;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_START;
    cfg_ch.wr_data   = 8'h00;
    tmpl             = {8'd126, 8'd255, 8'd6, 8'd239};
    frame_pos        = POS_START;
    for (int i = 0; i < STORE_DEPTH; i++) body_bytes[i] = 8'h00;
    mismatches       = 0;
    results_seen     = 0;
    stall_left       = 0;
    no_idle          = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_default_frames();
    test_reconfig_mid_frame();
    test_template_extremes();
    test_random_templates();
    test_default_traffic();
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
